>>> rtl/rrts_pkg.sv
// Shared types and constants of the round-robin task scheduler.
package rrts_pkg;

  typedef enum logic [2:0] {
    REQ_ADD      = 3'd0,
    REQ_REMOVE   = 3'd1,
    REQ_EXIT     = 3'd2,
    REQ_SETSTATE = 3'd3,
    REQ_SETPRIO  = 3'd4,
    REQ_QUERY    = 3'd5,
    REQ_TICK     = 3'd6,
    REQ_SWITCH   = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    ST_DEAD   = 2'd0,
    ST_ACTIVE = 2'd1,
    ST_PAUSED = 2'd2,
    ST_OTHER  = 2'd3
  } slot_st_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NOTFOUND = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_IMMORTAL = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    CFG_IDLE_PID = 1'b0,
    CFG_DEF_PRIO = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK_RD,
    S_LOOK_CHK,
    S_ADD,
    S_ACT,
    S_SW_RD,
    S_SW_CHK,
    S_IDLE_RD,
    S_IDLE_CHK,
    S_SW_FIN,
    S_SW_OUT,
    S_CUR_RD,
    S_DONE
  } fsm_t;

  localparam logic [7:0] STDOUT_CHANNEL = 8'd1;

  // One entry of the task table, apart from the slot state.
  typedef struct packed {
    logic [15:0] pid;
    logic [3:0]  prio;
    logic        immortal;
    logic [7:0]  in_ch;
    logic [7:0]  out_ch;
    logic [63:0] sp;
    logic [15:0] ss;
  } slot_t;

endpackage

>>> rtl/round_robin_task_scheduler_top.sv
// Top level of the round-robin task scheduler.
// The task table sits in one memory of TASK_SLOTS entries with a registered read;
// slot states sit in a flip-flop row so that reset kills every slot at once. One request is
// taken at a time, and the input stays closed from acceptance until the result has been taken.
// A pid lookup reads and then compares each slot it visits, for remove, set state, set
// priority and query. A switch writes back the caller's stack, walks the following slots
// one per cycle plus one final check, looks up the idle task by the same read and compare
// of each slot, and then finishes. The result waits in an output register.
module round_robin_task_scheduler_top #(
  parameter int TASK_SLOTS   = 16,
  parameter int PRIORITY_MAX = 15
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // req_type, target_pid, new_state, priority_request, add_priority, add_immortal,
  // in_channel, out_channel, stack_pointer, stack_segment, zero pad
  input  logic [143:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status, result_pid, task_state, next_sp, next_ss, keep_running, switch_needed,
  // finished, eof_signal, cur_in_channel, cur_out_channel
  output logic [119:0] m_tdata
);

  localparam int AW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CW = $clog2(TASK_SLOTS + 1);
  localparam logic [CW-1:0] SLOTS_C = CW'(TASK_SLOTS);
  localparam logic [AW-1:0] LAST_C = AW'(TASK_SLOTS - 1);

  // Input fields.
  rrts_pkg::req_t req_type;
  logic [15:0] target_pid;
  logic [1:0]  req_state;
  logic signed [15:0] priority_request;
  logic [3:0]  add_priority;
  logic        add_immortal;
  logic [7:0]  in_channel, out_channel;
  logic [63:0] stack_pointer;
  logic [15:0] stack_segment;

  logic [143:0] inreg;
  assign req_type         = rrts_pkg::req_t'(inreg[2:0]);
  assign target_pid       = inreg[18:3];
  assign req_state        = inreg[20:19];
  assign priority_request = inreg[36:21];
  assign add_priority     = inreg[40:37];
  assign add_immortal     = inreg[41];
  assign in_channel       = inreg[49:42];
  assign out_channel      = inreg[57:50];
  assign stack_pointer    = inreg[121:58];
  assign stack_segment    = inreg[137:122];

  logic [15:0] idle_pid;
  logic [3:0]  base_prio;

  logic [1:0]  slot_state [TASK_SLOTS];
  rrts_pkg::slot_t mem [TASK_SLOTS];
  rrts_pkg::slot_t rd;
  logic        mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  rrts_pkg::slot_t mem_wd;

  logic [AW-1:0] current_slot;
  logic [CW-1:0] live_count;
  logic [15:0]   next_pid;
  logic [4:0]    slice_ticks;

  rrts_pkg::fsm_t state, state_next;
  logic [AW-1:0] idx, idx_next;
  logic [CW-1:0] steps, seen;
  logic          found;
  logic [AW-1:0] hit;
  logic          hit_ok;

  // Result fields.
  logic [1:0]  o_status;
  logic [15:0] o_pid;
  logic [1:0]  o_state;
  logic [63:0] o_sp;
  logic [15:0] o_ss;
  logic o_keep, o_swn, o_fin, o_eof;
  logic [7:0]  o_in, o_out;

  logic [AW-1:0] first_dead;
  logic          any_dead;

  always_comb begin
    first_dead = '0;
    any_dead = 1'b0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (slot_state[i] == rrts_pkg::ST_DEAD) begin
        first_dead = AW'(i);
        any_dead = 1'b1;
      end
    end
  end

  logic [AW-1:0] idx_inc;
  assign idx_inc = (idx == LAST_C) ? '0 : idx + 1'b1;

  logic [15:0] look_pid;
  assign look_pid = (req_type == rrts_pkg::REQ_SWITCH) ? idle_pid : target_pid;
  logic look_match;
  assign look_match = (slot_state[idx] != rrts_pkg::ST_DEAD) && (rd.pid == look_pid);

  assign s_tready = (state == rrts_pkg::S_IDLE) && !m_tvalid;

  // Memory: one write and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd <= mem[mem_ra];
  end

  always_comb begin
    state_next = state;
    idx_next = idx;
    unique case (state)
      rrts_pkg::S_IDLE: begin
        if (s_tvalid && s_tready) begin
          unique case (rrts_pkg::req_t'(s_tdata[2:0]))
            rrts_pkg::REQ_ADD: state_next = rrts_pkg::S_ADD;
            rrts_pkg::REQ_REMOVE, rrts_pkg::REQ_SETSTATE, rrts_pkg::REQ_SETPRIO,
            rrts_pkg::REQ_QUERY: begin
              state_next = rrts_pkg::S_LOOK_RD;
              idx_next = '0;
            end
            rrts_pkg::REQ_EXIT, rrts_pkg::REQ_TICK: begin
              state_next = rrts_pkg::S_ACT;
              idx_next = current_slot;
            end
            rrts_pkg::REQ_SWITCH: begin
              state_next = rrts_pkg::S_SW_RD;
              idx_next = current_slot;
            end
            default: state_next = rrts_pkg::S_IDLE;
          endcase
        end
      end
      rrts_pkg::S_LOOK_RD: state_next = rrts_pkg::S_LOOK_CHK;
      rrts_pkg::S_LOOK_CHK: begin
        if (look_match || idx == LAST_C) begin
          state_next = rrts_pkg::S_ACT;
        end else begin
          idx_next = idx + 1'b1;
          state_next = rrts_pkg::S_LOOK_RD;
        end
      end
      rrts_pkg::S_ADD: state_next = rrts_pkg::S_CUR_RD;
      rrts_pkg::S_ACT: state_next = rrts_pkg::S_CUR_RD;
      rrts_pkg::S_SW_RD: begin
        state_next = rrts_pkg::S_SW_CHK;
        idx_next = current_slot;
      end
      rrts_pkg::S_SW_CHK: begin
        if (found || seen >= live_count || steps >= SLOTS_C) begin
          state_next = rrts_pkg::S_IDLE_RD;
          idx_next = '0;
        end else begin
          idx_next = idx_inc;
        end
      end
      rrts_pkg::S_IDLE_RD: state_next = rrts_pkg::S_IDLE_CHK;
      rrts_pkg::S_IDLE_CHK: begin
        if (look_match || idx == LAST_C) begin
          state_next = rrts_pkg::S_SW_FIN;
        end else begin
          idx_next = idx + 1'b1;
          state_next = rrts_pkg::S_IDLE_RD;
        end
      end
      rrts_pkg::S_SW_FIN: state_next = rrts_pkg::S_SW_OUT;
      rrts_pkg::S_SW_OUT: state_next = rrts_pkg::S_CUR_RD;
      rrts_pkg::S_CUR_RD: state_next = rrts_pkg::S_DONE;
      rrts_pkg::S_DONE: state_next = rrts_pkg::S_IDLE;
      default: state_next = rrts_pkg::S_IDLE;
    endcase
  end

  // Memory addressing and write data.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = current_slot;
    mem_wd = rd;
    mem_ra = idx_next;
    unique case (state)
      rrts_pkg::S_ADD: begin
        mem_we = any_dead && (live_count < SLOTS_C);
        mem_wa = first_dead;
        mem_wd.pid = next_pid;
        mem_wd.prio = add_priority;
        mem_wd.immortal = add_immortal;
        mem_wd.in_ch = in_channel;
        mem_wd.out_ch = out_channel;
        mem_wd.sp = stack_pointer;
        mem_wd.ss = stack_segment;
      end
      rrts_pkg::S_ACT: begin
        mem_wa = idx;
        if (req_type == rrts_pkg::REQ_SETPRIO && hit_ok) begin
          mem_we = 1'b1;
          if (priority_request > 16'(PRIORITY_MAX)) begin
            mem_wd.prio = 4'(PRIORITY_MAX);
          end else if (priority_request < 16'sd1) begin
            mem_wd.prio = base_prio;
          end else begin
            mem_wd.prio = priority_request[3:0];
          end
        end
      end
      rrts_pkg::S_SW_RD: begin
        mem_we = 1'b1;
        mem_wa = current_slot;
        mem_wd.sp = stack_pointer;
        mem_wd.ss = stack_segment;
        mem_ra = current_slot;
      end
      rrts_pkg::S_SW_FIN: mem_ra = (!found && hit_ok) ? hit : current_slot;
      rrts_pkg::S_CUR_RD: mem_ra = current_slot;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rrts_pkg::S_IDLE;
      idx <= '0;
      idle_pid <= '0;
      base_prio <= 4'd1;
      for (int i = 0; i < TASK_SLOTS; i++) slot_state[i] <= rrts_pkg::ST_DEAD;
      current_slot <= '0;
      live_count <= '0;
      next_pid <= '0;
      slice_ticks <= '0;
      m_tvalid <= 1'b0;
      found <= 1'b0;
      steps <= '0;
      seen <= '0;
      hit_ok <= 1'b0;
    end else begin
      state <= state_next;
      idx <= idx_next;
      if (cfg_we) begin
        if (cfg_index == rrts_pkg::CFG_IDLE_PID) idle_pid <= cfg_data;
        else base_prio <= cfg_data[3:0];
      end
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        rrts_pkg::S_IDLE: begin
          if (s_tvalid && s_tready) begin
            o_status <= rrts_pkg::STAT_OK;
            o_pid <= '0; o_state <= '0; o_sp <= '0; o_ss <= '0;
            o_keep <= 1'b0; o_swn <= 1'b0; o_fin <= 1'b0; o_eof <= 1'b0;
            hit_ok <= 1'b0;
            found <= 1'b0;
            steps <= '0;
            seen <= '0;
          end
        end
        rrts_pkg::S_LOOK_CHK: begin
          if (look_match) begin
            hit_ok <= 1'b1;
          end
        end
        rrts_pkg::S_ADD: begin
          if (any_dead && live_count < SLOTS_C) begin
            slot_state[first_dead] <= rrts_pkg::ST_ACTIVE;
            live_count <= live_count + 1'b1;
            next_pid <= next_pid + 1'b1;
            o_pid <= next_pid;
          end else begin
            o_status <= rrts_pkg::STAT_FULL;
          end
        end
        rrts_pkg::S_ACT: begin
          unique case (req_type)
            rrts_pkg::REQ_REMOVE, rrts_pkg::REQ_EXIT: begin
              if (req_type == rrts_pkg::REQ_REMOVE && !hit_ok) begin
                o_status <= rrts_pkg::STAT_NOTFOUND;
              end else if (req_type == rrts_pkg::REQ_REMOVE && rd.immortal) begin
                o_status <= rrts_pkg::STAT_IMMORTAL;
              end else if (req_type == rrts_pkg::REQ_EXIT &&
                           slot_state[idx] == rrts_pkg::ST_DEAD) begin
                o_status <= rrts_pkg::STAT_NOTFOUND;
              end else begin
                slot_state[idx] <= rrts_pkg::ST_DEAD;
                if (live_count != '0) live_count <= live_count - 1'b1;
                o_pid <= rd.pid;
                o_fin <= 1'b1;
                if (idx == current_slot) begin
                  slice_ticks <= 5'(rd.prio) + 5'd1;
                  o_swn <= 1'b1;
                end
                if (req_type == rrts_pkg::REQ_EXIT) begin
                  o_eof <= (rd.out_ch != rrts_pkg::STDOUT_CHANNEL);
                end
              end
            end
            rrts_pkg::REQ_SETSTATE: begin
              if (hit_ok) slot_state[idx] <= req_state;
              else o_status <= rrts_pkg::STAT_NOTFOUND;
            end
            rrts_pkg::REQ_SETPRIO: begin
              if (!hit_ok) o_status <= rrts_pkg::STAT_NOTFOUND;
            end
            rrts_pkg::REQ_QUERY: begin
              if (hit_ok) o_state <= slot_state[idx];
              else o_status <= rrts_pkg::STAT_NOTFOUND;
            end
            rrts_pkg::REQ_TICK: begin
              if (slice_ticks + 5'd1 < 5'(rd.prio)) begin
                slice_ticks <= slice_ticks + 5'd1;
                o_keep <= 1'b1;
              end
            end
            default: ;
          endcase
        end
        rrts_pkg::S_SW_CHK: begin
          if (!(found || seen >= live_count || steps >= SLOTS_C)) begin
            current_slot <= idx_inc;
            steps <= steps + 1'b1;
            if (slot_state[idx_inc] != rrts_pkg::ST_DEAD) seen <= seen + 1'b1;
            if (slot_state[idx_inc] == rrts_pkg::ST_ACTIVE) found <= 1'b1;
          end
        end
        rrts_pkg::S_IDLE_CHK: begin
          if (look_match) begin
            hit_ok <= 1'b1;
            hit <= idx;
          end
        end
        rrts_pkg::S_SW_FIN: begin
          slice_ticks <= '0;
          if (!found) begin
            if (hit_ok) begin
              current_slot <= hit;
              slot_state[hit] <= rrts_pkg::ST_ACTIVE;
            end else begin
              o_status <= rrts_pkg::STAT_NOTFOUND;
            end
          end
        end
        rrts_pkg::S_SW_OUT: begin
          // Pause idle only after the selected slot's pid is known.
          if (found && rd.pid != idle_pid && hit_ok) begin
            slot_state[hit] <= rrts_pkg::ST_PAUSED;
          end
          o_pid <= rd.pid;
          o_sp <= rd.sp;
          o_ss <= rd.ss;
        end
        rrts_pkg::S_DONE: begin
          o_in <= rd.in_ch;
          o_out <= rd.out_ch;
          m_tvalid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) inreg <= s_tdata;
  end

  // The current slot's channels are latched as the result goes out.
  assign m_tdata = {o_out, o_in, o_eof, o_fin, o_swn, o_keep, o_ss, o_sp,
                    o_state, o_pid, o_status};

endmodule
